// ===== rtl/oledf_pkg.sv =====
// Shared types, codes and constants for the OLED command/data framer.
// No dependencies; used by the window tracker, the top level and the testbench.
package oledf_pkg;

  // Default display geometry
  localparam int DISPLAY_COLUMNS_DEF = 128;
  localparam int DISPLAY_PAGES_DEF   = 8;

  // Request kinds
  localparam logic [1:0] KIND_INIT     = 2'd0;
  localparam logic [1:0] KIND_CONTRAST = 2'd1;
  localparam logic [1:0] KIND_INVERT   = 2'd2;
  localparam logic [1:0] KIND_DATA     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_COL_FIRST = 2'd0;
  localparam logic [1:0] REG_COL_LAST  = 2'd1;
  localparam logic [1:0] REG_ROW_FIRST = 2'd2;
  localparam logic [1:0] REG_ROW_LAST  = 2'd3;

  // Controller command bytes
  localparam logic [7:0] CMD_CONTRAST   = 8'h81;
  localparam logic [7:0] CMD_NORMAL     = 8'hA6;
  localparam logic [7:0] CMD_INVERSE    = 8'hA7;
  localparam logic [7:0] CMD_PAGE_START = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW    = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH   = 8'h10;

  // Start-up command list
  localparam int         INIT_LEN      = 25;
  localparam logic [4:0] INIT_LAST_IDX = 5'(INIT_LEN - 1);

  // Byte slots of a frame data burst: three header commands, then the data byte
  localparam logic [4:0] SLOT_PAGE     = 5'd0;
  localparam logic [4:0] SLOT_COL_LOW  = 5'd1;
  localparam logic [4:0] SLOT_COL_HIGH = 5'd2;
  localparam logic [4:0] SLOT_DATA     = 5'd3;

  // Header details handed from the window tracker at acceptance of a frame byte
  typedef struct packed {
    logic       hdr;   // byte opens a page row of the window
    logic [2:0] page;  // page for the page start command
    logic [6:0] col;   // window start column for the column commands
  } hdr_info_t;

  function automatic logic [7:0] init_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:  b = 8'hAE;
      5'd1:  b = 8'h81;
      5'd2:  b = 8'h7F;
      5'd3:  b = 8'hA6;
      5'd4:  b = 8'hA4;
      5'd5:  b = 8'h2E;
      5'd6:  b = 8'h20;
      5'd7:  b = 8'h02;
      5'd8:  b = 8'hA1;
      5'd9:  b = 8'hA8;
      5'd10: b = 8'h3F;
      5'd11: b = 8'hC8;
      5'd12: b = 8'hD3;
      5'd13: b = 8'h00;
      5'd14: b = 8'hDA;
      5'd15: b = 8'h12;
      5'd16: b = 8'hD5;
      5'd17: b = 8'h80;
      5'd18: b = 8'hD9;
      5'd19: b = 8'h22;
      5'd20: b = 8'hDB;
      5'd21: b = 8'h20;
      5'd22: b = 8'h8D;
      5'd23: b = 8'h14;
      5'd24: b = 8'hAF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/oledf_if.sv =====
// Valid/ready channel interfaces of the OLED framer: requests, output bytes, register writes.
// Depends on nothing; a beat moves at a clock edge with valid and ready both high.
interface oledf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] value;
  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

interface oledf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;
  modport source (output valid, output out_byte, output is_data, output last, input ready);
  modport sink (input valid, input out_byte, input is_data, input last, output ready);
endinterface

interface oledf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/oledf_window.sv =====
// Window registers and frame position counters of the OLED framer.
// Depends on oledf_pkg; gives the header details for the frame byte being accepted.
module oledf_window #(
  parameter int DISPLAY_COLUMNS = oledf_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_PAGES   = oledf_pkg::DISPLAY_PAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [6:0]            cfg_data,
  input  logic                  data_take,
  output oledf_pkg::hdr_info_t  info
);

  localparam logic [6:0] COL_MAX  = 7'(DISPLAY_COLUMNS - 1);
  localparam logic [2:0] PAGE_MAX = 3'(DISPLAY_PAGES - 1);

  logic [6:0] col_first, col_last, col_first_next, col_last_next;
  logic [5:0] row_first, row_last, row_first_next, row_last_next;
  logic [6:0] column_pos, column_pos_next;
  logic [2:0] page_pos, page_pos_next;

  logic [6:0] cf, cl, cl_raw, cf_new, cl_tmp;
  logic [2:0] ps, pe, pe_raw, ps_new, pe_tmp;
  logic [6:0] cur_col;
  logic [2:0] cur_page;

  // Clamp the window to the display and lift an end below its start
  always_comb begin
    cf     = (col_first > COL_MAX) ? COL_MAX : col_first;
    cl_raw = (col_last > COL_MAX) ? COL_MAX : col_last;
    cl     = (cl_raw < cf) ? cf : cl_raw;
    ps     = (row_first[5:3] > PAGE_MAX) ? PAGE_MAX : row_first[5:3];
    pe_raw = (row_last[5:3] > PAGE_MAX) ? PAGE_MAX : row_last[5:3];
    pe     = (pe_raw < ps) ? ps : pe_raw;
  end

  // Pull a position outside the window back to its start
  always_comb begin
    if (column_pos < cf || column_pos > cl || page_pos < ps || page_pos > pe) begin
      cur_col  = cf;
      cur_page = ps;
    end else begin
      cur_col  = column_pos;
      cur_page = page_pos;
    end
  end

  assign info.hdr  = (cur_col == cf);
  assign info.page = cur_page;
  assign info.col  = cf;

  // Register writes
  always_comb begin
    col_first_next = col_first;
    col_last_next  = col_last;
    row_first_next = row_first;
    row_last_next  = row_last;
    if (cfg_we) begin
      unique case (cfg_index)
        oledf_pkg::REG_COL_FIRST: col_first_next = cfg_data;
        oledf_pkg::REG_COL_LAST:  col_last_next  = cfg_data;
        oledf_pkg::REG_ROW_FIRST: row_first_next = cfg_data[5:0];
        oledf_pkg::REG_ROW_LAST:  row_last_next  = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Window start as seen after the write, for the frame restart
  always_comb begin
    cf_new = (col_first_next > COL_MAX) ? COL_MAX : col_first_next;
    ps_new = (row_first_next[5:3] > PAGE_MAX) ? PAGE_MAX : row_first_next[5:3];
    cl_tmp = cl;
    pe_tmp = pe;
  end

  // Advance the position: restart on a write, walk and wrap on a frame byte
  always_comb begin
    column_pos_next = column_pos;
    page_pos_next   = page_pos;
    priority if (cfg_we) begin
      column_pos_next = cf_new;
      page_pos_next   = ps_new;
    end else if (data_take) begin
      if (cur_col >= cl_tmp) begin
        column_pos_next = cf;
        page_pos_next   = (cur_page >= pe_tmp) ? ps : cur_page + 3'd1;
      end else begin
        column_pos_next = cur_col + 7'd1;
        page_pos_next   = cur_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_first  <= 7'd0;
      col_last   <= 7'd127;
      row_first  <= 6'd0;
      row_last   <= 6'd63;
      column_pos <= 7'd0;
      page_pos   <= 3'd0;
    end else begin
      col_first  <= col_first_next;
      col_last   <= col_last_next;
      row_first  <= row_first_next;
      row_last   <= row_last_next;
      column_pos <= column_pos_next;
      page_pos   <= page_pos_next;
    end
  end

endmodule

// ===== rtl/oled_command_data_framer.sv =====
// Top level of the OLED command/data framer: request sink, byte sequencer, output register.
// Depends on oledf_pkg, the channel interfaces in oledf_if and oledf_window.

// Turns requests into the byte stream of a page-addressed monochrome OLED controller, each
// byte tagged as data or command and the final byte of every burst marked with last. The
// sequencer sends one byte per clock into the output register unless it holds a stalled byte.
// A frame byte inside a page row is a single byte, one that opens a page row of the window is
// 4 (page, column low, column high, data), contrast is 2, invert 1 and the start-up list 25.
// A new request is taken in the cycle the previous burst hands over its
// last byte, so frame bytes stream at one per clock while the output side keeps up.
// Register writes are taken at any time, one per clock, and put the frame position back to
// the window start; they are meant for idle periods only.
module oled_command_data_framer #(
  parameter int DISPLAY_COLUMNS = oledf_pkg::DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_PAGES   = oledf_pkg::DISPLAY_PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  oledf_req_if.sink     req,
  oledf_byte_if.source  resp,
  oledf_cfg_if.sink     cfg
);

  oledf_pkg::hdr_info_t info;
  logic                 req_take, data_take;

  // Burst register
  logic       busy;
  logic [1:0] kind;
  logic [7:0] val;
  logic [2:0] page;
  logic [6:0] col;
  logic [4:0] idx;

  // Output register
  logic       ovalid;
  logic [7:0] obyte;
  logic       odata;
  logic       olast;

  logic [7:0] cur_byte;
  logic       cur_data;
  logic       cur_last;
  logic       out_load, gen_fire, done;

  assign cfg.ready = 1'b1;

  assign out_load  = !ovalid || resp.ready;
  assign gen_fire  = busy && out_load;
  assign done      = gen_fire && cur_last;
  assign req.ready = !busy || done;
  assign req_take  = req.valid && req.ready;
  assign data_take = req_take && (req.req_type == oledf_pkg::KIND_DATA);

  oledf_window #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .data_take (data_take),
    .info      (info)
  );

  // Pick the byte for the current slot of the burst
  always_comb begin
    cur_byte = 8'h00;
    cur_data = 1'b0;
    cur_last = 1'b0;
    unique case (kind)
      oledf_pkg::KIND_INIT: begin
        cur_byte = oledf_pkg::init_byte(idx);
        cur_last = (idx == oledf_pkg::INIT_LAST_IDX);
      end
      oledf_pkg::KIND_CONTRAST: begin
        cur_byte = (idx == 5'd0) ? oledf_pkg::CMD_CONTRAST : val;
        cur_last = (idx != 5'd0);
      end
      oledf_pkg::KIND_INVERT: begin
        cur_byte = (val != 8'h00) ? oledf_pkg::CMD_INVERSE : oledf_pkg::CMD_NORMAL;
        cur_last = 1'b1;
      end
      oledf_pkg::KIND_DATA: begin
        unique case (idx)
          oledf_pkg::SLOT_PAGE:     cur_byte = oledf_pkg::CMD_PAGE_START | {5'd0, page};
          oledf_pkg::SLOT_COL_LOW:  cur_byte = oledf_pkg::CMD_COL_LOW | {4'd0, col[3:0]};
          oledf_pkg::SLOT_COL_HIGH: cur_byte = oledf_pkg::CMD_COL_HIGH | {5'd0, col[6:4]};
          default: begin
            cur_byte = val;
            cur_data = 1'b1;
            cur_last = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Load a new burst, advance through its slots, drop it after its last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_take) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      kind <= req.req_type;
      val  <= req.value;
      page <= info.page;
      col  <= info.col;
      idx  <= (req.req_type == oledf_pkg::KIND_DATA && !info.hdr) ?
              oledf_pkg::SLOT_DATA : 5'd0;
    end else if (gen_fire && !cur_last) begin
      idx <= idx + 5'd1;
    end
  end

  // Output register: hold while stalled, refill when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      obyte <= cur_byte;
      odata <= cur_data;
      olast <= cur_last;
    end
  end

  assign resp.valid    = ovalid;
  assign resp.out_byte = obyte;
  assign resp.is_data  = odata;
  assign resp.last     = olast;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the OLED command/data framer: drives requests and register
// writes, predicts every output byte and checks it. Depends on oledf_pkg, oledf_if and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_OFF     = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 15;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {SINK_ALWAYS, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } link_byte_t;

  // Start-up list as the controller expects it
  localparam logic [7:0] STARTUP_CMDS [0:24] = '{
    8'hAE, 8'h81, 8'h7F, 8'hA6, 8'hA4, 8'h2E, 8'h20, 8'h02, 8'hA1, 8'hA8, 8'h3F, 8'hC8,
    8'hD3, 8'h00, 8'hDA, 8'h12, 8'hD5, 8'h80, 8'hD9, 8'h22, 8'hDB, 8'h20, 8'h8D, 8'h14,
    8'hAF
  };

  // Tracks window registers and frame position, and holds the bytes still owed
  class burst_tracker;
    logic [6:0] col_first, col_last, row_first, row_last;
    logic [6:0] column_pos;
    logic [2:0] page_pos;
    link_byte_t pending_bytes[$];
    int mismatches, bytes_checked, requests_seen, headers_seen, windows_set;

    function new();
      col_first = 7'd0;
      col_last = 7'd127;
      row_first = 7'd0;
      row_last = 7'd63;
      column_pos = 7'd0;
      page_pos = 3'd0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] d);
      case (idx)
        oledf_pkg::REG_COL_FIRST: col_first = d;
        oledf_pkg::REG_COL_LAST:  col_last = d;
        oledf_pkg::REG_ROW_FIRST: row_first = {1'b0, d[5:0]};
        oledf_pkg::REG_ROW_LAST:  row_last = {1'b0, d[5:0]};
        default: ;
      endcase
      // Any write puts the frame back to the window start
      column_pos = col_first;
      page_pos = row_first[5:3];
      windows_set++;
    endfunction

    function void queue_byte(logic [7:0] b, logic d, logic l);
      pending_bytes.push_back({b, d, l});
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] v);
      logic [6:0] cf, cl;
      logic [2:0] ps, pe;
      requests_seen++;
      case (kind)
        oledf_pkg::KIND_INIT: begin
          for (int i = 0; i < oledf_pkg::INIT_LEN; i++)
            queue_byte(STARTUP_CMDS[i], 1'b0, i == oledf_pkg::INIT_LEN - 1);
        end
        oledf_pkg::KIND_CONTRAST: begin
          queue_byte(oledf_pkg::CMD_CONTRAST, 1'b0, 1'b0);
          queue_byte(v, 1'b0, 1'b1);
        end
        oledf_pkg::KIND_INVERT:
          queue_byte((v != 8'd0) ? oledf_pkg::CMD_INVERSE : oledf_pkg::CMD_NORMAL, 1'b0, 1'b1);
        default: begin
          // A window end below its start collapses onto the start
          cf = col_first;
          cl = (col_last < cf) ? cf : col_last;
          ps = row_first[5:3];
          pe = (row_last[5:3] < ps) ? ps : row_last[5:3];
          if (column_pos < cf || column_pos > cl || page_pos < ps || page_pos > pe) begin
            column_pos = cf;
            page_pos = ps;
          end
          // Open each page row with the page and column start commands
          if (column_pos == cf) begin
            queue_byte(oledf_pkg::CMD_PAGE_START | {5'd0, page_pos}, 1'b0, 1'b0);
            queue_byte(oledf_pkg::CMD_COL_LOW | {4'd0, cf[3:0]}, 1'b0, 1'b0);
            queue_byte(oledf_pkg::CMD_COL_HIGH | {5'd0, cf[6:4]}, 1'b0, 1'b0);
            headers_seen++;
          end
          queue_byte(v, 1'b1, 1'b1);
          // Advance, wrapping at the window edges
          if (column_pos >= cl) begin
            column_pos = cf;
            page_pos = (page_pos >= pe) ? ps : page_pos + 3'd1;
          end else begin
            column_pos = column_pos + 7'd1;
          end
        end
      endcase
    endfunction

    function void check_byte(link_byte_t got);
      link_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected beat: byte %02h data %0b last %0b",
                   $realtime, got.out_byte, got.is_data, got.last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] beat mismatch: byte %02h/%02h data %0b/%0b last %0b/%0b (exp/got)",
                   $realtime, want.out_byte, got.out_byte, want.is_data, got.is_data,
                   want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  oledf_req_if  req_ch ();
  oledf_byte_if byte_ch ();
  oledf_cfg_if  cfg_ch ();

  oled_command_data_framer dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (byte_ch),
    .cfg  (cfg_ch)
  );

  burst_tracker tracker = new();

  sink_mode_t  sink_mode = SINK_ALWAYS;
  logic [15:0] ready_pattern = 16'hFFFF;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  always #2 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = oledf_pkg::KIND_INIT;
    req_ch.value = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = oledf_pkg::REG_COL_FIRST;
    cfg_ch.data = 7'd0;
    byte_ch.ready = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d beats outstanding", tracker.pending_bytes.size());
      $display("FAIL oled_command_data_framer");
      $finish;
    end
  end

  // Receiver: long hold-off first, otherwise the phase's stall pattern
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      byte_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      case (sink_mode)
        SINK_PATTERN: begin
          byte_ch.ready <= ready_pattern[0];
          ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
        SINK_RANDOM: byte_ch.ready <= ($urandom_range(0, 3) != 0);
        default: byte_ch.ready <= 1'b1;
      endcase
    end
  end

  // Check every output beat
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready)
      tracker.check_byte({byte_ch.out_byte, byte_ch.is_data, byte_ch.last});
  end

  task automatic push_request(logic [1:0] kind, logic [7:0] v);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(kind, v);
  endtask

  task automatic idle_request(int cycles);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Send one request, breaking the stream into bursts with gaps
  task automatic offer(logic [1:0] kind, logic [7:0] v);
    if (gaps_on && burst_left == 0) begin
      idle_request($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    push_request(kind, v);
  endtask

  task automatic wait_drained();
    idle_request(1);
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_window(logic [6:0] cf, logic [6:0] cl, logic [6:0] rf, logic [6:0] rl);
    write_reg(oledf_pkg::REG_COL_FIRST, cf);
    write_reg(oledf_pkg::REG_COL_LAST, cl);
    write_reg(oledf_pkg::REG_ROW_FIRST, rf);
    write_reg(oledf_pkg::REG_ROW_LAST, rl);
  endtask

  // Choose a window: small, extreme, inverted or fully random
  task automatic pick_window(int style);
    int cf, cl, rf, rl;
    case (style)
      1: begin
        cf = $urandom_range(0, 127);
        cl = cf + $urandom_range(0, 4);
        if (cl > 127) cl = 127;
        rf = $urandom_range(0, 63);
        rl = rf + $urandom_range(0, 15);
        if (rl > 63) rl = 63;
      end
      2: begin
        cf = $urandom_range(0, 1) ? 127 : 0;
        cl = $urandom_range(0, 1) ? 127 : 0;
        rf = $urandom_range(0, 1) ? 63 : 0;
        rl = $urandom_range(0, 1) ? 63 : 0;
      end
      3: begin
        cf = $urandom_range(1, 127);
        cl = $urandom_range(0, cf - 1);
        rf = $urandom_range(8, 63);
        rl = $urandom_range(0, rf - 8);
      end
      default: begin
        cf = $urandom_range(0, 127);
        cl = $urandom_range(0, 127);
        rf = $urandom_range(0, 127);
        rl = $urandom_range(0, 127);
      end
    endcase
    set_window(cf[6:0], cl[6:0], rf[6:0], rl[6:0]);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)       offer(oledf_pkg::KIND_INIT, 8'($urandom_range(0, 255)));
    else if (r < 16) offer(oledf_pkg::KIND_CONTRAST, 8'($urandom_range(0, 255)));
    else if (r < 26) offer(oledf_pkg::KIND_INVERT,
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd0);
    else             offer(oledf_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every kind and value extremes under the reset window
    gaps_on = 1'b0;
    push_request(oledf_pkg::KIND_INIT, 8'h00);
    push_request(oledf_pkg::KIND_CONTRAST, 8'h00);
    push_request(oledf_pkg::KIND_CONTRAST, 8'hFF);
    push_request(oledf_pkg::KIND_INVERT, 8'h00);
    push_request(oledf_pkg::KIND_INVERT, 8'h01);
    push_request(oledf_pkg::KIND_INVERT, 8'h80);
    push_request(oledf_pkg::KIND_INVERT, 8'hFF);
    push_request(oledf_pkg::KIND_DATA, 8'h00);
    push_request(oledf_pkg::KIND_DATA, 8'hFF);
    wait_drained();

    // Both window ends below their starts: one column on the last page
    set_window(7'd126, 7'd2, 7'd63, 7'd0);
    push_request(oledf_pkg::KIND_DATA, 8'hAA);
    push_request(oledf_pkg::KIND_DATA, 8'h55);
    push_request(oledf_pkg::KIND_DATA, 8'h01);
    wait_drained();

    // Three columns over two pages, walked past a full wrap
    set_window(7'd31, 7'd33, 7'd48, 7'd63);
    for (int i = 0; i < 7; i++) push_request(oledf_pkg::KIND_DATA, 8'(8'h10 + i));
    wait_drained();

    // Random phases over varied windows and stall behaviour
    for (int p = 0; p < PHASES; p++) begin
      pick_window((p == 4) ? 0 : (p % 3 == 1) ? 2 : (p % 3 == 2) ? 3 : 1);
      sink_mode = sink_mode_t'(p % 3);
      ready_pattern = 16'($urandom) | 16'h0101;
      gaps_on = (p % 4 != 1);
      burst_left = 0;
      if (p == 3) begin
        // Hold the receiver off while requests keep coming, to fill the block
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 30; i++)
          push_request(oledf_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          // Pause the sender until all output has come back
          if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
          random_request();
        end
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (tracker.pending_bytes.size() != 0) begin
      tracker.mismatches++;
      $display("%0d expected beats never arrived", tracker.pending_bytes.size());
    end
    $display("Covered %0d requests and %0d beats, %0d row headers, %0d register writes",
             tracker.requests_seen, tracker.bytes_checked, tracker.headers_seen,
             tracker.windows_set);
    $display("Mismatches: %0d", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("PASS oled_command_data_framer");
    end else begin
      $display("FAIL oled_command_data_framer");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/oledf_pkg.sv
rtl/oledf_if.sv
rtl/oledf_window.sv
rtl/oled_command_data_framer.sv
sim/tb.sv
